// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types and constants for the ray / box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned AXES    = 3;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_HIGH_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_NEAR_ZERO  = 3'd6;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                        miss;
    logic                        par;
    logic signed [COORD_W-1:0]   t_lo;
    logic signed [COORD_W-1:0]   t_hi;
    logic signed [COORD_W-1:0]   org;
    logic signed [COORD_W-1:0]   dir;
  } lane_res_t;

endpackage

// ===== rtl/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div
// pipelined signed divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
module rbsi_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  num_neg,
  input  logic [rbsi_pkg::DIFF_W+FRAC_BITS-1:0] num_mag,
  input  logic                                  den_neg,
  input  logic [rbsi_pkg::COORD_W-1:0]          den_mag,
  output logic signed [rbsi_pkg::COORD_W-1:0]   quo
);

  localparam int unsigned NUM_W = rbsi_pkg::DIFF_W + FRAC_BITS;
  localparam int unsigned CW    = rbsi_pkg::COORD_W;

  logic [NUM_W-1:0] n_r   [NUM_W+1];
  logic [CW:0]      rem_r [NUM_W+1];
  logic [NUM_W-1:0] q_r   [NUM_W+1];
  logic [CW-1:0]    d_r   [NUM_W+1];
  logic             neg_r [NUM_W+1];
  logic signed [CW-1:0] quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= num_mag;
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      d_r[0]   <= den_mag;
      neg_r[0] <= num_neg ^ den_neg;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [CW:0]      trial;
    logic             ge;
    logic [NUM_W-1:0] q_nxt;
    always_comb begin
      trial = {rem_r[i][CW-1:0], n_r[i][NUM_W-1-i]};
      ge    = trial >= {1'b0, d_r[i]};
      q_nxt = q_r[i];
      q_nxt[NUM_W-1-i] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1]   <= n_r[i];
        rem_r[i+1] <= ge ? (trial - {1'b0, d_r[i]}) : trial;
        q_r[i+1]   <= q_nxt;
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  logic [NUM_W-1:0] q_fin;
  logic signed [CW-1:0] quo_nxt;
  always_comb begin
    q_fin = q_r[NUM_W];
    if (neg_r[NUM_W]) begin
      if (q_fin > NUM_W'(33'h0_8000_0000)) quo_nxt = rbsi_pkg::C_MIN;
      else quo_nxt = CW'(-q_fin[CW-1:0]);
    end else begin
      if (q_fin > NUM_W'(33'h0_7fff_ffff)) quo_nxt = rbsi_pkg::C_MAX;
      else quo_nxt = q_fin[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

// ===== rtl/rbsi_lane.sv =====
// ----------------------------------------------------------------------------
// rbsi_lane
// one axis: slab flags, entry and exit parameters, ordered interval
// ----------------------------------------------------------------------------
module rbsi_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic signed [rbsi_pkg::COORD_W-1:0]        org,
  input  logic signed [rbsi_pkg::COORD_W-1:0]        dir,
  input  logic signed [rbsi_pkg::COORD_W-1:0]        box_low,
  input  logic signed [rbsi_pkg::COORD_W-1:0]        box_high,
  input  logic        [rbsi_pkg::LIMIT_W-1:0]        limit,
  output rbsi_pkg::lane_res_t                        res
);

  localparam int unsigned NUM_W = rbsi_pkg::DIFF_W + FRAC_BITS;
  localparam int unsigned LAT   = NUM_W + 2;
  localparam int unsigned CW    = rbsi_pkg::COORD_W;
  localparam int unsigned DW    = rbsi_pkg::DIFF_W;

  logic signed [DW-1:0] diff_lo, diff_hi;
  logic [DW-1:0]        mag_lo, mag_hi;
  logic [CW-1:0]        dir_mag;
  logic                 par, miss;
  logic signed [CW-1:0] t_a, t_b;

  always_comb begin
    diff_lo = DW'(box_low) - DW'(org);
    diff_hi = DW'(box_high) - DW'(org);
    mag_lo  = diff_lo[DW-1] ? DW'(-diff_lo) : diff_lo;
    mag_hi  = diff_hi[DW-1] ? DW'(-diff_hi) : diff_hi;
    dir_mag = dir[CW-1] ? CW'(-dir) : dir;
    par     = (dir == '0) || (dir_mag < CW'(limit));
    miss    = (box_low > box_high) || (par && ((org < box_low) || (org > box_high)));
  end

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk     (clk),
    .en      (en),
    .num_neg (diff_lo[DW-1]),
    .num_mag ({mag_lo, FRAC_BITS'(0)}),
    .den_neg (dir[CW-1]),
    .den_mag (dir_mag),
    .quo     (t_a)
  );

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk     (clk),
    .en      (en),
    .num_neg (diff_hi[DW-1]),
    .num_mag ({mag_hi, FRAC_BITS'(0)}),
    .den_neg (dir[CW-1]),
    .den_mag (dir_mag),
    .quo     (t_b)
  );

  logic                 miss_r [LAT];
  logic                 par_r  [LAT];
  logic signed [CW-1:0] org_r  [LAT];
  logic signed [CW-1:0] dir_r  [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      miss_r[0] <= miss;
      par_r[0]  <= par;
      org_r[0]  <= org;
      dir_r[0]  <= dir;
      for (int i = 1; i < LAT; i++) begin
        miss_r[i] <= miss_r[i-1];
        par_r[i]  <= par_r[i-1];
        org_r[i]  <= org_r[i-1];
        dir_r[i]  <= dir_r[i-1];
      end
    end
  end

  always_comb begin
    res.miss = miss_r[LAT-1];
    res.par  = par_r[LAT-1];
    res.org  = org_r[LAT-1];
    res.dir  = dir_r[LAT-1];
    res.t_lo = (t_a > t_b) ? t_b : t_a;
    res.t_hi = (t_a > t_b) ? t_a : t_b;
  end

endmodule

// ===== rtl/rbsi_merge.sv =====
// ----------------------------------------------------------------------------
// rbsi_merge
// interval merge across lanes, then hit point with saturation
// ----------------------------------------------------------------------------
module rbsi_merge #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  rbsi_pkg::lane_res_t                       lane [rbsi_pkg::AXES],
  output logic                                      hit,
  output logic signed [rbsi_pkg::COORD_W-1:0]       pt   [rbsi_pkg::AXES]
);

  localparam int unsigned CW  = rbsi_pkg::COORD_W;
  localparam int unsigned AX  = rbsi_pkg::AXES;
  localparam int unsigned PW  = 2 * CW;
  localparam int unsigned SW  = PW - FRAC_BITS + 1;

  logic                 hit_nxt;
  logic signed [CW-1:0] tmin, tmax;

  always_comb begin
    hit_nxt = 1'b1;
    tmin    = rbsi_pkg::C_MIN;
    tmax    = rbsi_pkg::C_MAX;
    for (int a = 0; a < AX; a++) begin
      if (lane[a].miss) hit_nxt = 1'b0;
      if (!lane[a].par) begin
        if (lane[a].t_lo > tmin) tmin = lane[a].t_lo;
        if (lane[a].t_hi < tmax) tmax = lane[a].t_hi;
      end
    end
    if (tmin > tmax) hit_nxt = 1'b0;
  end

  logic                 hit_a_r, hit_b_r, hit_r;
  logic signed [CW-1:0] tmin_a_r;
  logic signed [CW-1:0] org_a_r [AX];
  logic signed [CW-1:0] dir_a_r [AX];
  logic signed [CW-1:0] org_b_r [AX];
  logic signed [PW-1:0] prod_b_r [AX];
  logic signed [CW-1:0] pt_r    [AX];
  logic signed [SW-1:0] sum     [AX];
  logic signed [CW-1:0] pt_nxt  [AX];

  always_comb begin
    for (int a = 0; a < AX; a++) begin
      sum[a] = SW'(org_b_r[a]) + SW'(prod_b_r[a] >>> FRAC_BITS);
      if (!hit_b_r) pt_nxt[a] = '0;
      else if (sum[a] > SW'(rbsi_pkg::C_MAX)) pt_nxt[a] = rbsi_pkg::C_MAX;
      else if (sum[a] < SW'(rbsi_pkg::C_MIN)) pt_nxt[a] = rbsi_pkg::C_MIN;
      else pt_nxt[a] = sum[a][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_a_r  <= hit_nxt;
      tmin_a_r <= tmin;
      hit_b_r  <= hit_a_r;
      hit_r    <= hit_b_r;
      for (int a = 0; a < AX; a++) begin
        org_a_r[a]  <= lane[a].org;
        dir_a_r[a]  <= lane[a].dir;
        org_b_r[a]  <= org_a_r[a];
        prod_b_r[a] <= dir_a_r[a] * tmin_a_r;
        pt_r[a]     <= pt_nxt[a];
      end
    end
  end

  assign hit = hit_r;
  assign pt  = pt_r;

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// ray against axis-aligned box, slab method, three axis lanes and a merge
//
//   port group   dir   contents
//   in_*         in    ray: origin x/y/z, direction x/y/z
//   out_*        out   hit flag, hit point x/y/z
//   cfg_*        in    box bounds, near-zero limit
//
// one item per cycle while the output is not stalled; bit-per-stage dividers
// of FRAC_BITS + 33 stages, two divider edge registers, three merge stages
// the whole pipeline advances when the output register is empty or taken
// reset clears valid flags and loads the empty box, so every ray misses
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // hit_x, hit_y, hit_z
  output logic [0:0]   out_tuser,  // hit
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned CW  = rbsi_pkg::COORD_W;
  localparam int unsigned AX  = rbsi_pkg::AXES;
  localparam int unsigned TOT = rbsi_pkg::DIFF_W + FRAC_BITS + 2 + 3;

  logic signed [CW-1:0] low_r  [AX];
  logic signed [CW-1:0] high_r [AX];
  logic [rbsi_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AX; a++) begin
        low_r[a]  <= rbsi_pkg::C_MAX;
        high_r[a] <= rbsi_pkg::C_MIN;
      end
      limit_r <= rbsi_pkg::LIMIT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rbsi_pkg::REG_BOX_LOW_X:  low_r[0]  <= cfg_data;
        rbsi_pkg::REG_BOX_LOW_Y:  low_r[1]  <= cfg_data;
        rbsi_pkg::REG_BOX_LOW_Z:  low_r[2]  <= cfg_data;
        rbsi_pkg::REG_BOX_HIGH_X: high_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_HIGH_Y: high_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_HIGH_Z: high_r[2] <= cfg_data;
        rbsi_pkg::REG_NEAR_ZERO:  limit_r   <= cfg_data[rbsi_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v_r [TOT];

  assign en        = !v_r[TOT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < TOT; i++) v_r[i] <= v_r[i-1];
    end
  end

  rbsi_pkg::lane_res_t lane_res [AX];

  for (genvar a = 0; a < AX; a++) begin : g_lane
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .en       (en),
      .org      (in_tdata[a*CW +: CW]),
      .dir      (in_tdata[(a+AX)*CW +: CW]),
      .box_low  (low_r[a]),
      .box_high (high_r[a]),
      .limit    (limit_r),
      .res      (lane_res[a])
    );
  end

  logic                 hit;
  logic signed [CW-1:0] pt [AX];

  rbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk  (clk),
    .en   (en),
    .lane (lane_res),
    .hit  (hit),
    .pt   (pt)
  );

  assign out_tvalid   = v_r[TOT-1];
  assign out_tuser[0] = hit;
  assign out_tdata    = {pt[2], pt[1], pt[0]};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss with nonzero point");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result after reset");

endmodule

// ===== verif/ray_box_slab_intersect_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_test
// self-checking bench for the ray / box slab intersection block: a table of
// directed rays, then random rays against several boxes, with random idling
// on both sides and one long output hold-off; results checked in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

  localparam int FRAC = 16;
  localparam int LAT = FRAC + 38;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic signed [31:0] dz, dy, dx, oz, oy, ox;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] pz, py, px;
  } hit_t;

  typedef struct {
    ray_t ray;
    bit   typed;
    hit_t want;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_wr_en = 0;
  logic [191:0] in_tdata = '0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire in_tready, out_tvalid;
  wire [95:0] out_tdata;
  wire [0:0] out_tuser;

  ray_box_slab_intersect #(.FRAC_BITS(FRAC)) uut (.*);

  initial forever #1 clk = ~clk;

  longint box_lo[3], box_hi[3];
  longint nz_limit;
  hit_t pending_hits[$];
  int errors = 0, idle_cycles = 0, hits_seen = 0, results_seen = 0;
  bit quiet = 0, hold_long = 0, stalled_once = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic hit_t slab_hit(ray_t r);
    longint o[3], d[3], t0, t1, s, mag, tmin, tmax, p;
    bit h;
    hit_t res;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    tmin = -64'sd2147483648; tmax = 64'sd2147483647; h = 1;
    for (int a = 0; a < 3 && h; a++) begin
      mag = d[a] < 0 ? -d[a] : d[a];
      if (box_lo[a] > box_hi[a]) h = 0;
      else if (d[a] == 0 || mag < nz_limit) begin
        if (o[a] < box_lo[a] || o[a] > box_hi[a]) h = 0;
      end else begin
        t0 = clamp32(((box_lo[a] - o[a]) * (64'sd1 << FRAC)) / d[a]);
        t1 = clamp32(((box_hi[a] - o[a]) * (64'sd1 << FRAC)) / d[a]);
        if (t0 > t1) begin s = t0; t0 = t1; t1 = s; end
        if (tmin > t1 || t0 > tmax) h = 0;
        else begin
          if (t0 > tmin) tmin = t0;
          if (t1 < tmax) tmax = t1;
        end
      end
    end
    res = '0;
    res.hit = h;
    if (h) begin
      p = clamp32(o[0] + ((d[0] * tmin) >>> FRAC)); res.px = p[31:0];
      p = clamp32(o[1] + ((d[1] * tmin) >>> FRAC)); res.py = p[31:0];
      p = clamp32(o[2] + ((d[2] * tmin) >>> FRAC)); res.pz = p[31:0];
    end
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    if (idx < rbsi_pkg::REG_BOX_HIGH_X) box_lo[idx] = longint'($signed(val));
    else if (idx < rbsi_pkg::REG_NEAR_ZERO)
      box_hi[idx - rbsi_pkg::REG_BOX_HIGH_X] = longint'($signed(val));
    else if (idx == rbsi_pkg::REG_NEAR_ZERO) nz_limit = val & 32'h1ffff;
  endtask

  task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz, int nz);
    write_reg(rbsi_pkg::REG_BOX_LOW_X, lx); write_reg(rbsi_pkg::REG_BOX_LOW_Y, ly);
    write_reg(rbsi_pkg::REG_BOX_LOW_Z, lz); write_reg(rbsi_pkg::REG_BOX_HIGH_X, hx);
    write_reg(rbsi_pkg::REG_BOX_HIGH_Y, hy); write_reg(rbsi_pkg::REG_BOX_HIGH_Z, hz);
    write_reg(rbsi_pkg::REG_NEAR_ZERO, nz);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic send_ray(ray_t r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= r;
    pending_hits.push_back(slab_hit(r));
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] rand_coord(int spread);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 2 * spread)) - spread;
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom();
      2: return $signed($urandom_range(0, 4)) - 2;
      3: return 32'h80000000;
      default: return $signed($urandom_range(0, 32'h40000)) - 32'h20000;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord(32'h80000); r.oy = rand_coord(32'h80000);
    r.oz = rand_coord(32'h80000);
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    return r;
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    hit_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata};
      results_seen++;
      hits_seen += got.hit;
      if (pending_hits.size() == 0) begin
        $error("result with nothing expected"); errors++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
        end
        if (got.px !== want.px) begin
          $error("hit_x exp %0d got %0d", want.px, got.px); errors++;
        end
        if (got.py !== want.py) begin
          $error("hit_y exp %0d got %0d", want.py, got.py); errors++;
        end
        if (got.pz !== want.pz) begin
          $error("hit_z exp %0d got %0d", want.pz, got.pz); errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 0;
        repeat (LAT * 3) @(posedge clk);
        hold_long = 0; stalled_once = 1;
        out_tready <= 1;
      end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_tready <= 1;
      end else out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(int ox, int oy, int oz, int dx, int dy, int dz,
                         bit typed = 0, hit_t want = '0);
    row_t w;
    w.ray = {32'(dz), 32'(dy), 32'(dx), 32'(oz), 32'(oy), 32'(ox)};
    w.typed = typed; w.want = want;
    rows.push_back(w);
  endtask

  initial begin
    hit_t h;
    box_lo = '{default: 64'sd2147483647};
    box_hi = '{default: -64'sd2147483648};
    nz_limit = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset box is empty: misses
    add_row(0, 0, 0, 32'h10000, 0, 0, 1, '0);
    add_row(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 1, '0);
    foreach (rows[i]) begin
      h = slab_hit(rows[i].ray);
      if (rows[i].typed && h !== rows[i].want) begin
        $error("table row %0d disagrees", i); errors++;
      end
      send_ray(rows[i].ray);
    end
    drain();
    rows.delete();

    set_box(-32'h10000, -32'h10000, -32'h10000, 32'h10000, 32'h10000, 32'h10000, 0);
    add_row(-32'h50000, 0, 0, 32'h10000, 0, 0);
    add_row(0, 0, 0, 0, 0, 0);
    add_row(32'h20000, 0, 0, 0, 0, 0, 1, '0);
    add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1);
    add_row(32'h80000000, 0, 0, 1, 0, 0);
    add_row(0, 0, 0, 1, 1, 1);
    add_row(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    add_row(-32'h30000, -32'h30000, -32'h30000, 32'h10000, 32'h10000, 32'h10000);
    add_row(-32'h30000, 32'h30000, 0, 32'h10000, 32'h10000, 0);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    foreach (rows[i]) send_ray(rows[i].ray);
    drain();
    rows.delete();

    set_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h10000);
    add_row(0, 0, 0, 32'hffff, -32'hffff, 32'h10000);
    add_row(32'h7fffffff, 32'h80000000, 0, -32'h10000, 32'h10000, 0);
    add_row(5, 5, 5, -32'h20000, 32'h30000, 32'h7fffffff);
    foreach (rows[i]) send_ray(rows[i].ray);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_box(-32'h40000, -32'h40000, -32'h40000, 32'h40000, 32'h40000, 32'h40000, 1);
        1: set_box(32'h80000000, -32'h20000, 0, 32'h10000, 32'h7fffffff, 32'h50000, 32'h10000);
        2: set_box(32'h10000, 32'h10000, 32'h10000, -32'h10000, 32'h10000, 32'h10000, 2);
        default: set_box(-$urandom_range(0, 32'h80000), -$urandom_range(0, 32'h80000),
                         -$urandom_range(0, 32'h80000), $urandom_range(0, 32'h80000),
                         $urandom_range(0, 32'h80000), $urandom_range(0, 32'h80000),
                         $urandom_range(0, 32'h1ffff));
      endcase
      if (ph == 4) quiet = 1;
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (ph == 1 && n == 40) hold_long = 1;
        send_ray(rand_ray());
      end
      drain();
    end

    $display("rays checked: %0d, hits among them: %0d", results_seen, hits_seen);
    $display("boxes: reset, unit, full range, empty, random; long stall seen: %0d",
             stalled_once);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rbsi_pkg.sv
rtl/rbsi_div.sv
rtl/rbsi_lane.sv
rtl/rbsi_merge.sv
rtl/ray_box_slab_intersect.sv
verif/ray_box_slab_intersect_test.sv
